// ===== rtl/tplh_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, widths and codes for the triangle point locate / height block.
// Used by every module under rtl/; depends on nothing.
package tplh_pkg;

    // coordinate format
    localparam int CW    = 32;             // coordinate width, signed
    localparam int FB    = 16;             // fraction bits
    localparam int TOLW  = 40;             // tolerance register width
    localparam int VFRAC = 40;             // fraction bits of plane_tolerance_sq

    // derived arithmetic widths
    localparam int DW    = CW + 1;         // coordinate difference, signed
    localparam int PW    = 2 * DW;         // difference product, signed
    localparam int NW    = PW + 1;         // cross product component, signed
    localparam int MW    = NW - 1;         // magnitude of a cross product component
    localparam int HW    = MW / 2;         // half of a magnitude
    localparam int SQW   = 2 * MW;         // square of a component
    localparam int SUMW  = SQW + 2;        // sum of three squares
    localparam int NCH   = 4;              // chunks of the sum for the tolerance product
    localparam int CHW   = (SUMW + NCH - 1) / NCH;
    localparam int PPW   = TOLW + CHW;     // tolerance partial product
    localparam int RHW   = PPW + CHW * (NCH - 1);
    localparam int TMW   = MW + DW;        // numerator term magnitude
    localparam int NUMW  = TMW + 2;        // numerator, signed
    localparam int DVW   = NUMW + 1;       // dividend 2|num| + |ny|
    localparam int VSW   = MW + 1;         // divisor 2|ny|
    localparam int QB    = CW + 2;         // quotient bits kept before saturation
    localparam int HTW   = QB + 2;         // height before clamping, signed

    // stream widths
    localparam int NIN      = 12;
    localparam int IN_TDW   = ((NIN * CW + 7) / 8) * 8;
    localparam int RES_BITS = CW + 5;
    localparam int OUT_TDW  = ((RES_BITS + 7) / 8) * 8;

    // configuration registers
    localparam int CFG_IW = 1;
    localparam logic [CFG_IW-1:0] REG_SIDE_TOL  = 1'd0;
    localparam logic [CFG_IW-1:0] REG_PLANE_TOL = 1'd1;
    localparam logic [TOLW-1:0] SIDE_TOL_RST  =
        TOLW'(((64'd1 << (2 * FB)) + 64'd500) / 64'd1000);
    localparam logic [TOLW-1:0] PLANE_TOL_RST = 40'd110;

    // exit edge codes
    localparam logic [1:0] EDGE_AB   = 2'd0;
    localparam logic [1:0] EDGE_BC   = 2'd1;
    localparam logic [1:0] EDGE_CA   = 2'd2;
    localparam logic [1:0] EDGE_NONE = 2'd3;

    // clamp limits
    localparam logic [CW-1:0] RMAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic [CW-1:0] RMIN = {1'b1, {(CW-1){1'b0}}};
    localparam logic signed [HTW-1:0] HMAX = {{(HTW-CW+1){1'b0}}, {(CW-1){1'b1}}};
    localparam logic signed [HTW-1:0] HMIN = ~HMAX;

    typedef struct packed {
        logic [CW-1:0] ax, ay, az;
        logic [CW-1:0] bx, by, bz;
        logic [CW-1:0] cx, cy, cz;
        logic [CW-1:0] px, py, pz;
    } t_item;

    typedef struct packed {
        logic [1:0]    exit_edge;
        logic [CW-1:0] ay;
        logic [CW-1:0] py;
    } t_tag;

    // geometry stage result
    typedef struct packed {
        t_tag          tag;
        logic [NW-1:0] nx, ny, nz;
        logic [DW-1:0] dpx, dpz;
    } t_geo;

    // divider input
    typedef struct packed {
        t_tag           tag;
        logic           vertical;
        logic           qneg;
        logic [DVW-1:0] dividend;
        logic [VSW-1:0] divisor;
    } t_dvin;

    typedef struct packed {
        logic          sat;
        logic          vertical;
        logic [CW-1:0] height;
        logic [1:0]    exit_edge;
        logic          in_tri;
    } t_res;

    // signed difference of two coordinates, one bit wider
    function automatic logic signed [DW-1:0] diff(input logic [CW-1:0] a,
                                                   input logic [CW-1:0] b);
        return DW'($signed(a)) - DW'($signed(b));
    endfunction

endpackage

// ===== rtl/tplh_geom.sv =====
`timescale 1ns / 1ps
// Edge vectors, exact XZ cross products, edge side test and plane normal.
// Four register stages; depends on tplh_pkg.
module tplh_geom (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_valid,
    input  tplh_pkg::t_item            i_item,
    input  logic [tplh_pkg::TOLW-1:0]  i_side_tol,
    output logic                       o_valid,
    output tplh_pkg::t_geo             o_geo
);
    import tplh_pkg::*;

    logic [3:0] r_v;

    logic [CW-1:0] vx [3];
    logic [CW-1:0] vz [3];

    // stage 1: differences
    logic signed [DW-1:0] r1_ex [3];
    logic signed [DW-1:0] r1_ez [3];
    logic signed [DW-1:0] r1_qx [3];
    logic signed [DW-1:0] r1_qz [3];
    logic signed [DW-1:0] r1_acx, r1_acz, r1_aby, r1_acy;
    logic [CW-1:0]        r_ay [3];
    logic [CW-1:0]        r_py [3];

    // stage 2: products
    logic signed [PW-1:0] r2_sa [3];
    logic signed [PW-1:0] r2_sb [3];
    logic signed [PW-1:0] r2_wa, r2_wb, r2_xa, r2_xb, r2_za, r2_zb;
    logic signed [DW-1:0] r2_dpx, r2_dpz;

    // stage 3: cross products
    logic signed [NW-1:0] r3_side [3];
    logic signed [NW-1:0] r3_wind, r3_nx, r3_nz;
    logic signed [DW-1:0] r3_dpx, r3_dpz;

    // stage 4 side test
    logic signed [NW:0] sc  [3];
    logic signed [NW:0] tst [3];
    logic [2:0]         rej;
    logic [1:0]         exit_c;
    t_geo               r4_geo;

    assign vx[0] = i_item.ax;
    assign vx[1] = i_item.bx;
    assign vx[2] = i_item.cx;
    assign vz[0] = i_item.az;
    assign vz[1] = i_item.bz;
    assign vz[2] = i_item.cz;

    // valid bits follow the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[2:0], i_valid};
        end
    end

    // stage 1: edge end minus start, position minus start
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_ex[0] <= diff(vx[1], vx[0]);
            r1_ez[0] <= diff(vz[1], vz[0]);
            r1_ex[1] <= diff(vx[2], vx[1]);
            r1_ez[1] <= diff(vz[2], vz[1]);
            r1_ex[2] <= diff(vx[0], vx[2]);
            r1_ez[2] <= diff(vz[0], vz[2]);
            for (int i = 0; i < 3; i++) begin
                r1_qx[i] <= diff(i_item.px, vx[i]);
                r1_qz[i] <= diff(i_item.pz, vz[i]);
            end
            r1_acx <= diff(i_item.cx, i_item.ax);
            r1_acz <= diff(i_item.cz, i_item.az);
            r1_aby <= diff(i_item.by, i_item.ay);
            r1_acy <= diff(i_item.cy, i_item.ay);
            r_ay[0] <= i_item.ay;
            r_py[0] <= i_item.py;
            r_ay[1] <= r_ay[0];
            r_py[1] <= r_py[0];
            r_ay[2] <= r_ay[1];
            r_py[2] <= r_py[1];
        end
    end

    // stage 2: all 33x33 products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r2_sa[i] <= r1_ez[i] * r1_qx[i];
                r2_sb[i] <= r1_ex[i] * r1_qz[i];
            end
            r2_wa  <= r1_ez[0] * r1_acx;
            r2_wb  <= r1_ex[0] * r1_acz;
            r2_xa  <= r1_aby * r1_acz;
            r2_xb  <= r1_ez[0] * r1_acy;
            r2_za  <= r1_ex[0] * r1_acy;
            r2_zb  <= r1_aby * r1_acx;
            r2_dpx <= r1_qx[0];
            r2_dpz <= r1_qz[0];
        end
    end

    // stage 3: differences of products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r3_side[i] <= NW'(r2_sa[i]) - NW'(r2_sb[i]);
            end
            r3_wind <= NW'(r2_wa) - NW'(r2_wb);
            r3_nx   <= NW'(r2_xa) - NW'(r2_xb);
            r3_nz   <= NW'(r2_za) - NW'(r2_zb);
            r3_dpx  <= r2_dpx;
            r3_dpz  <= r2_dpz;
        end
    end

    // stage 4: winding-adjusted side below minus tolerance, first edge wins
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            sc[i]  = r3_wind[NW-1] ? -((NW+1)'(r3_side[i])) : (NW+1)'(r3_side[i]);
            tst[i] = sc[i] + (NW+1)'($signed({1'b0, i_side_tol}));
            rej[i] = tst[i][NW];
        end
        if (rej[0]) begin
            exit_c = EDGE_AB;
        end else if (rej[1]) begin
            exit_c = EDGE_BC;
        end else if (rej[2]) begin
            exit_c = EDGE_CA;
        end else begin
            exit_c = EDGE_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_geo.tag.exit_edge <= exit_c;
            r4_geo.tag.ay        <= r_ay[2];
            r4_geo.tag.py        <= r_py[2];
            r4_geo.nx            <= r3_nx;
            r4_geo.ny            <= r3_wind;
            r4_geo.nz            <= r3_nz;
            r4_geo.dpx           <= r3_dpx;
            r4_geo.dpz           <= r3_dpz;
        end
    end

    assign o_valid = r_v[3];
    assign o_geo   = r4_geo;

endmodule

// ===== rtl/tplh_plane.sv =====
`timescale 1ns / 1ps
// Plane steepness test against plane_tolerance_sq and the height numerator.
// Seven register stages, multiplies split into 33-bit halves; depends on tplh_pkg.
module tplh_plane (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_valid,
    input  tplh_pkg::t_geo             i_geo,
    input  logic [tplh_pkg::TOLW-1:0]  i_plane_tol,
    output logic                       o_valid,
    output tplh_pkg::t_dvin            o_dv
);
    import tplh_pkg::*;

    localparam int NST = 7;

    logic [NST-1:0] r_v;
    t_tag           r_tag [NST];

    logic [NW-1:0]  n_in [3];

    // stage 1: magnitudes
    logic [MW-1:0]  r1_m [3];
    logic [DW-1:0]  r1_dx, r1_dz;
    logic           r1_sx, r1_sz, r1_sy;

    // stage 2: partial products
    logic [2*HW-1:0] r2_hh [3];
    logic [2*HW-1:0] r2_hl [3];
    logic [2*HW-1:0] r2_ll [3];
    logic [HW+DW-1:0] r2_xh, r2_xl, r2_zh, r2_zl;
    logic           r2_sx, r2_sz, r2_sy;
    logic [MW-1:0]  r2_my;

    // stage 3: squares and numerator terms
    logic [SQW-1:0] r3_sq [3];
    logic [TMW-1:0] r3_tx, r3_tz;
    logic           r3_sx, r3_sz, r3_sy;
    logic [MW-1:0]  r3_my;

    // stage 4: sum of squares and numerator
    logic signed [NUMW-1:0] tsx, tsz;
    logic [SUMW-1:0]        r4_sum;
    logic [SQW-1:0]         r4_sqy;
    logic signed [NUMW-1:0] r4_num;
    logic                   r4_sy;
    logic [MW-1:0]          r4_my;

    // stage 5: tolerance partial products, divider operands
    logic [NCH*CHW-1:0]     sum_pad;
    logic [NUMW-2:0]        an;
    logic [PPW-1:0]         r5_pp [NCH];
    logic [SQW-1:0]         r5_sqy;
    logic [DVW-1:0]         r5_dvd;
    logic [VSW-1:0]         r5_dvs;
    logic                   r5_qneg;

    // stage 6: both sides of the steepness compare
    logic [RHW-1:0]         rhs_c;
    logic [RHW-1:0]         r6_rhs, r6_lhs;
    logic [DVW-1:0]         r6_dvd;
    logic [VSW-1:0]         r6_dvs;
    logic                   r6_qneg;

    t_dvin                  r7_dv;

    assign n_in[0] = i_geo.nx;
    assign n_in[1] = i_geo.ny;
    assign n_in[2] = i_geo.nz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[NST-2:0], i_valid};
        end
    end

    // tag rides along unchanged
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tag[0] <= i_geo.tag;
            for (int k = 1; k < NST; k++) begin
                r_tag[k] <= r_tag[k-1];
            end
        end
    end

    // stage 1
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r1_m[k] <= n_in[k][NW-1] ? MW'(-$signed(n_in[k])) : MW'(n_in[k]);
            end
            r1_dx <= i_geo.dpx[DW-1] ? DW'(-$signed(i_geo.dpx)) : i_geo.dpx;
            r1_dz <= i_geo.dpz[DW-1] ? DW'(-$signed(i_geo.dpz)) : i_geo.dpz;
            r1_sx <= i_geo.nx[NW-1] ^ i_geo.dpx[DW-1];
            r1_sz <= i_geo.nz[NW-1] ^ i_geo.dpz[DW-1];
            r1_sy <= i_geo.ny[NW-1];
        end
    end

    // stage 2: 33x33 unsigned products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r2_hh[k] <= r1_m[k][MW-1:HW] * r1_m[k][MW-1:HW];
                r2_hl[k] <= r1_m[k][MW-1:HW] * r1_m[k][HW-1:0];
                r2_ll[k] <= r1_m[k][HW-1:0] * r1_m[k][HW-1:0];
            end
            r2_xh <= r1_m[0][MW-1:HW] * r1_dx;
            r2_xl <= r1_m[0][HW-1:0] * r1_dx;
            r2_zh <= r1_m[2][MW-1:HW] * r1_dz;
            r2_zl <= r1_m[2][HW-1:0] * r1_dz;
            r2_sx <= r1_sx;
            r2_sz <= r1_sz;
            r2_sy <= r1_sy;
            r2_my <= r1_m[1];
        end
    end

    // stage 3
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r3_sq[k] <= (SQW'(r2_hh[k]) << (2 * HW)) + (SQW'(r2_hl[k]) << (HW + 1))
                          + SQW'(r2_ll[k]);
            end
            r3_tx <= (TMW'(r2_xh) << HW) + TMW'(r2_xl);
            r3_tz <= (TMW'(r2_zh) << HW) + TMW'(r2_zl);
            r3_sx <= r2_sx;
            r3_sz <= r2_sz;
            r3_sy <= r2_sy;
            r3_my <= r2_my;
        end
    end

    // stage 4
    assign tsx = r3_sx ? -$signed(NUMW'(r3_tx)) : $signed(NUMW'(r3_tx));
    assign tsz = r3_sz ? -$signed(NUMW'(r3_tz)) : $signed(NUMW'(r3_tz));

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_sum <= SUMW'(r3_sq[0]) + SUMW'(r3_sq[1]) + SUMW'(r3_sq[2]);
            r4_sqy <= r3_sq[1];
            r4_num <= tsx + tsz;
            r4_sy  <= r3_sy;
            r4_my  <= r3_my;
        end
    end

    // stage 5
    assign sum_pad = (NCH*CHW)'(r4_sum);
    assign an      = r4_num[NUMW-1] ? (NUMW-1)'(-r4_num) : (NUMW-1)'(r4_num);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < NCH; j++) begin
                r5_pp[j] <= i_plane_tol * sum_pad[j*CHW +: CHW];
            end
            r5_sqy  <= r4_sqy;
            r5_dvd  <= DVW'({an, 1'b0}) + DVW'(r4_my);
            r5_dvs  <= {r4_my, 1'b0};
            r5_qneg <= r4_num[NUMW-1] ^ r4_sy;
        end
    end

    // stage 6
    always_comb begin
        rhs_c = '0;
        for (int j = 0; j < NCH; j++) begin
            rhs_c = rhs_c + (RHW'(r5_pp[j]) << (j * CHW));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r6_rhs  <= rhs_c;
            r6_lhs  <= RHW'(r5_sqy) << VFRAC;
            r6_dvd  <= r5_dvd;
            r6_dvs  <= r5_dvs;
            r6_qneg <= r5_qneg;
        end
    end

    // stage 7: vertical when ny^2 * 2^40 <= tol * |N|^2
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r7_dv.tag      <= r_tag[NST-2];
            r7_dv.vertical <= (r6_lhs <= r6_rhs);
            r7_dv.qneg     <= r6_qneg;
            r7_dv.dividend <= r6_dvd;
            r7_dv.divisor  <= r6_dvs;
        end
    end

    assign o_valid = r_v[NST-1];
    assign o_dv    = r7_dv;

endmodule

// ===== rtl/tplh_div.sv =====
`timescale 1ns / 1ps
// Pipelined restoring divider, one quotient bit a stage, then height clamp.
// QB + 2 register stages; depends on tplh_pkg.
module tplh_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  tplh_pkg::t_dvin   i_dv,
    output logic              o_valid,
    output tplh_pkg::t_res    o_res
);
    import tplh_pkg::*;

    localparam int NST = QB + 2;

    logic [NST-1:0] r_v;
    logic [DVW-1:0] r_rem  [QB+1];
    logic [VSW-1:0] r_dvs  [QB+1];
    logic [QB-1:0]  r_q    [QB+1];
    logic           r_ovf  [QB+1];
    logic           r_vert [QB+1];
    logic           r_qneg [QB+1];
    t_tag           r_tag  [QB+1];

    logic signed [HTW-1:0] ya, hq, hs;
    t_res                  res_c, r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[NST-2:0], i_valid};
        end
    end

    // stage 0: quotient too large for the kept bits means a clamped height
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= i_dv.dividend;
            r_dvs[0]  <= i_dv.divisor;
            r_q[0]    <= '0;
            r_ovf[0]  <= {1'b0, i_dv.dividend} >= ((DVW+1)'(i_dv.divisor) << QB);
            r_vert[0] <= i_dv.vertical;
            r_qneg[0] <= i_dv.qneg;
            r_tag[0]  <= i_dv.tag;
        end
    end

    // one quotient bit per stage, MSB first
    for (genvar k = 1; k <= QB; k++) begin : g_step
        localparam int B = QB - k;
        logic [DVW:0] trial;

        assign trial = {1'b0, r_rem[k-1]} - ((DVW+1)'(r_dvs[k-1]) << B);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!trial[DVW]) begin
                    r_rem[k] <= trial[DVW-1:0];
                    r_q[k]   <= r_q[k-1] | (QB'(1) << B);
                end else begin
                    r_rem[k] <= r_rem[k-1];
                    r_q[k]   <= r_q[k-1];
                end
                r_dvs[k]  <= r_dvs[k-1];
                r_ovf[k]  <= r_ovf[k-1];
                r_vert[k] <= r_vert[k-1];
                r_qneg[k] <= r_qneg[k-1];
                r_tag[k]  <= r_tag[k-1];
            end
        end
    end

    // final stage: height = A.y - signed quotient, clamped; P.y on a vertical plane
    assign ya = HTW'($signed(r_tag[QB].ay));
    assign hq = $signed(HTW'(r_q[QB]));
    assign hs = r_qneg[QB] ? (ya + hq) : (ya - hq);

    always_comb begin
        res_c.exit_edge = r_tag[QB].exit_edge;
        res_c.in_tri    = (r_tag[QB].exit_edge == EDGE_NONE);
        res_c.vertical  = r_vert[QB];
        res_c.sat       = 1'b0;
        res_c.height    = hs[CW-1:0];
        if (r_vert[QB]) begin
            res_c.height = r_tag[QB].py;
        end else if (r_ovf[QB]) begin
            res_c.sat    = 1'b1;
            res_c.height = r_qneg[QB] ? RMAX : RMIN;
        end else if (hs > HMAX) begin
            res_c.sat    = 1'b1;
            res_c.height = RMAX;
        end else if (hs < HMIN) begin
            res_c.sat    = 1'b1;
            res_c.height = RMIN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res <= res_c;
        end
    end

    assign o_valid = r_v[NST-1];
    assign o_res   = r_res;

endmodule

// ===== rtl/triangle_point_locate_height.sv =====
`timescale 1ns / 1ps
// Top level: stream ports, tolerance registers, pipeline and output skid stage.
// Instantiates tplh_geom, tplh_plane, tplh_div; depends on tplh_pkg.
//
// Each input transaction carries one triangle (A, B, C) and a query position,
// twelve signed Q16.16 words. Each output transaction carries the inside flag,
// the first rejecting edge (AB, BC, CA or none), the plane height at the
// position's X/Z, the vertical-plane flag and the clamp flag.
// From input acceptance to output valid a transaction passes through 4 geometry
// stages, 7 plane-test stages, 36 divider stages (operand setup, one stage per
// quotient bit for 34 bits, clamp) and the output register.
// Throughput is one transaction per cycle while the skid register is empty.
// The two tolerance registers are written through i_cfg_*, one per cycle; the user
// must write them only while no transaction is in flight; the block does not enforce this.
// Reset (synchronous, active low) clears all pipeline valid bits, empties the
// output and skid registers and loads the default tolerances.
// When the receiver stalls, the result waits in the output register and the
// next one moves into a skid register; only when that is full does the whole
// pipeline hold and s_axis_tready drop. Nothing is lost or repeated.
module triangle_point_locate_height (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // ax, ay, az, bx, by, bz, cx, cy, cz, px, py, pz (32 bits each, low first)
    input  logic [tplh_pkg::IN_TDW-1:0]        s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // inside_res[0], exit_edge[2:1], surface_height[34:3], plane_vertical[35],
    // height_saturated[36], zero pad
    output logic [tplh_pkg::OUT_TDW-1:0]       m_axis_tdata,
    input  logic                               i_cfg_we,
    input  logic [tplh_pkg::CFG_IW-1:0]        i_cfg_index,
    input  logic [tplh_pkg::TOLW-1:0]          i_cfg_data
);
    import tplh_pkg::*;

    logic [TOLW-1:0] r_side_tol, r_plane_tol;
    logic            pipe_en;
    t_item           item;
    logic            geo_v, dv_v, res_v;
    t_geo            geo;
    t_dvin           dv;
    t_res            res;
    logic            r_out_v, r_skid_v;
    t_res            r_out, r_skid;
    logic            out_taken;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side_tol  <= SIDE_TOL_RST;
            r_plane_tol <= PLANE_TOL_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_SIDE_TOL:  r_side_tol  <= i_cfg_data;
                REG_PLANE_TOL: r_plane_tol <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // unpack input fields
    assign item.ax = s_axis_tdata[0*CW  +: CW];
    assign item.ay = s_axis_tdata[1*CW  +: CW];
    assign item.az = s_axis_tdata[2*CW  +: CW];
    assign item.bx = s_axis_tdata[3*CW  +: CW];
    assign item.by = s_axis_tdata[4*CW  +: CW];
    assign item.bz = s_axis_tdata[5*CW  +: CW];
    assign item.cx = s_axis_tdata[6*CW  +: CW];
    assign item.cy = s_axis_tdata[7*CW  +: CW];
    assign item.cz = s_axis_tdata[8*CW  +: CW];
    assign item.px = s_axis_tdata[9*CW  +: CW];
    assign item.py = s_axis_tdata[10*CW +: CW];
    assign item.pz = s_axis_tdata[11*CW +: CW];

    // pipeline moves whenever the skid register is free
    assign pipe_en       = !r_skid_v;
    assign s_axis_tready = pipe_en;

    tplh_geom u_geom (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (pipe_en),
        .i_valid    (s_axis_tvalid),
        .i_item     (item),
        .i_side_tol (r_side_tol),
        .o_valid    (geo_v),
        .o_geo      (geo)
    );

    tplh_plane u_plane (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (pipe_en),
        .i_valid     (geo_v),
        .i_geo       (geo),
        .i_plane_tol (r_plane_tol),
        .o_valid     (dv_v),
        .o_dv        (dv)
    );

    tplh_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (pipe_en),
        .i_valid (dv_v),
        .i_dv    (dv),
        .o_valid (res_v),
        .o_res   (res)
    );

    // output register plus skid register
    assign out_taken = r_out_v & m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (out_taken) begin
                r_skid_v <= 1'b0;
            end
        end else if (res_v) begin
            if (!r_out_v || out_taken) begin
                r_out_v <= 1'b1;
            end else begin
                r_skid_v <= 1'b1;
            end
        end else if (out_taken) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_v) begin
            if (out_taken) begin
                r_out <= r_skid;
            end
        end else if (res_v) begin
            if (!r_out_v || out_taken) begin
                r_out <= res;
            end else begin
                r_skid <= res;
            end
        end
    end

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = OUT_TDW'({r_out.sat, r_out.vertical, r_out.height,
                                     r_out.exit_edge, r_out.in_tri});

    // skid holds a result only behind a waiting output
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid register full while output register empty");

    // inside flag agrees with the exit edge
    a_inside_edge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v |-> (r_out.in_tri == (r_out.exit_edge == EDGE_NONE)))
        else $error("inside flag disagrees with exit edge");

    // a vertical plane returns the position height unclamped
    a_vert_nosat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && r_out.vertical) |-> !r_out.sat)
        else $error("clamp flag set on vertical plane");

endmodule

// ===== tb/sv/tplh_checker.sv =====
`timescale 1ns / 1ps
// Result checker for triangle_point_locate_height: watches both stream channels,
// predicts each result from the accepted input and compares field by field.
// Depends on tplh_pkg for widths and exit edge codes.
module tplh_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        i_in_ready,
    input  logic [tplh_pkg::IN_TDW-1:0] i_in_data,
    input  logic                        i_out_valid,
    input  logic                        i_out_ready,
    input  logic [tplh_pkg::OUT_TDW-1:0] i_out_data,
    input  logic                        i_cfg_we,
    input  logic [tplh_pkg::CFG_IW-1:0] i_cfg_index,
    input  logic [tplh_pkg::TOLW-1:0]   i_cfg_data,
    output int                          o_fail_count,
    output int                          o_pending
);
    import tplh_pkg::*;

    typedef logic signed [255:0] t_big;

    typedef struct packed {
        logic          sat;
        logic          vertical;
        logic [CW-1:0] height;
        logic [1:0]    exit_edge;
        logic          in_tri;
    } t_loc_result;

    logic [TOLW-1:0] side_tol_q;
    logic [TOLW-1:0] plane_tol_q;
    t_loc_result     expected_results[$];

    assign o_pending = expected_results.size();

    function automatic t_big coord(input logic [IN_TDW-1:0] d, input int idx);
        logic signed [CW-1:0] v;
        v = d[idx*CW +: CW];
        return t_big'(v);
    endfunction

    // exact integer model of edge tests and plane height
    function automatic t_loc_result locate(input logic [IN_TDW-1:0] d);
        t_big vx[3], vy[3], vz[3];
        t_big px, py, pz, abx, aby, abz, acx, acy, acz;
        t_big wind, side, nx, ny, nz, lhs, rhs, num, an, ad, q, h, hmax, hmin;
        t_loc_result r;
        int e;
        for (int i = 0; i < 3; i++) begin
            vx[i] = coord(d, 3*i);
            vy[i] = coord(d, 3*i+1);
            vz[i] = coord(d, 3*i+2);
        end
        px = coord(d, 9); py = coord(d, 10); pz = coord(d, 11);
        abx = vx[1]-vx[0]; aby = vy[1]-vy[0]; abz = vz[1]-vz[0];
        acx = vx[2]-vx[0]; acy = vy[2]-vy[0]; acz = vz[2]-vz[0];
        wind = abz*acx - abx*acz;
        r = '0;
        r.exit_edge = EDGE_NONE;
        for (int i = 0; i < 3; i++) begin
            if (r.exit_edge == EDGE_NONE) begin
                e = (i + 1) % 3;
                side = (vz[e]-vz[i])*(px-vx[i]) - (vx[e]-vx[i])*(pz-vz[i]);
                if (wind < 0) side = -side;
                if (side < -t_big'({1'b0, side_tol_q})) r.exit_edge = 2'(i);
            end
        end
        r.in_tri = (r.exit_edge == EDGE_NONE);
        nx = aby*acz - abz*acy;
        ny = wind;
        nz = abx*acy - aby*acx;
        lhs = (ny*ny) <<< 40;
        rhs = t_big'({1'b0, plane_tol_q}) * (nx*nx + ny*ny + nz*nz);
        if (lhs <= rhs) begin
            r.vertical = 1'b1;
            r.height = py[CW-1:0];
        end else begin
            num = nx*(px-vx[0]) + nz*(pz-vz[0]);
            an = (num < 0) ? -num : num;
            ad = (ny < 0) ? -ny : ny;
            q = (2*an + ad) / (2*ad);
            if ((num < 0) != (ny < 0)) q = -q;
            h = vy[0] - q;
            hmax = (t_big'(1) <<< (CW-1)) - 1;
            hmin = -(t_big'(1) <<< (CW-1));
            if (h > hmax) begin h = hmax; r.sat = 1'b1; end
            else if (h < hmin) begin h = hmin; r.sat = 1'b1; end
            r.height = h[CW-1:0];
        end
        return r;
    endfunction

    // register shadow, prediction and comparison
    always @(posedge i_clk) begin
        t_loc_result act, exp_r;
        if (!i_rst_n) begin
            side_tol_q  <= SIDE_TOL_RST;
            plane_tol_q <= PLANE_TOL_RST;
            expected_results.delete();
            o_fail_count <= 0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == REG_SIDE_TOL) side_tol_q <= i_cfg_data;
                else if (i_cfg_index == REG_PLANE_TOL) plane_tol_q <= i_cfg_data;
            end
            if (i_in_valid && i_in_ready) expected_results.push_back(locate(i_in_data));
            if (i_out_valid && i_out_ready) begin
                act = i_out_data[RES_BITS-1:0];
                if (expected_results.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("unexpected result transaction %h", act);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_r = expected_results.pop_front();
                    if (act !== exp_r) begin
                        if (o_fail_count < 10)
                            $display({"mismatch: exp in=%b edge=%0d h=%h v=%b s=%b",
                                      " | act in=%b edge=%0d h=%h v=%b s=%b"},
                                exp_r.in_tri, exp_r.exit_edge, exp_r.height,
                                exp_r.vertical, exp_r.sat, act.in_tri,
                                act.exit_edge, act.height, act.vertical, act.sat);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

// ===== tb/sv/tb_triangle_point_locate_height.sv =====
`timescale 1ns / 1ps
// Testbench top for triangle_point_locate_height: clock, reset, register writes,
// directed and random triangle queries with random stalls, and the verdict.
// Depends on tplh_pkg, the block and tplh_checker.
module tb_triangle_point_locate_height;
    import tplh_pkg::*;

    localparam int WATCHDOG = 20000;
    localparam int DRAIN    = 60;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [IN_TDW-1:0]    s_axis_tdata;   // ax, ay, az, bx, by, bz, cx, cy, cz, px, py, pz
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [OUT_TDW-1:0]   m_axis_tdata;   // inside, exit_edge, height, vertical, sat, pad
    logic                 i_cfg_we;
    logic [CFG_IW-1:0]    i_cfg_index;
    logic [TOLW-1:0]      i_cfg_data;
    int                   fail_count;
    int                   pending;
    int                   idle_cycles;
    int                   out_gap;
    logic                 stalls_on;

    triangle_point_locate_height u_top (.*);

    tplh_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(s_axis_tvalid), .i_in_ready(s_axis_tready), .i_in_data(s_axis_tdata),
        .i_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .i_out_data(m_axis_tdata),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always begin
        i_clk = 1'b0; #5;
        i_clk = 1'b1; #5;
    end

    function automatic int gap_len();
        if (!stalls_on) return 0;
        if ($urandom_range(0, 99) < 60) return 0;
        if ($urandom_range(0, 99) < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // receiver stalls: runs of not-ready cycles, mostly short
    always @(posedge i_clk) begin
        int g;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            out_gap       <= 0;
        end else if (out_gap > 0) begin
            m_axis_tready <= 1'b0;
            out_gap       <= out_gap - 1;
        end else begin
            g = gap_len();
            m_axis_tready <= (g == 0);
            out_gap       <= (g > 0) ? g - 1 : 0;
        end
    end

    // watchdog: cycles without any transaction
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic logic [CW-1:0] rnd_coord(input int mode);
        case (mode)
            0: return CW'($signed($urandom_range(0, 2000)) - 1000) <<< FB;
            1: return $urandom;
            2: return ($urandom_range(0, 1)) ? RMAX : RMIN;
            default: return CW'($signed($urandom_range(0, 200)) - 100);
        endcase
    endfunction

    function automatic logic [IN_TDW-1:0] rnd_item();
        logic [IN_TDW-1:0] d;
        int mode;
        mode = ($urandom_range(0, 9) < 6) ? 0 : $urandom_range(1, 3);
        for (int i = 0; i < NIN; i++) d[i*CW +: CW] = rnd_coord(mode);
        if ($urandom_range(0, 9) == 0) d[0 +: 3*CW] = d[3*CW +: 3*CW];  // degenerate
        if ($urandom_range(0, 9) < 3) begin
            // position at the X/Z centroid, to keep it inside for most triangles
            d[9*CW +: CW]  = CW'(($signed(d[0 +: CW]) + $signed(d[3*CW +: CW])
                             + $signed(d[6*CW +: CW])) / 3);
            d[11*CW +: CW] = CW'(($signed(d[2*CW +: CW]) + $signed(d[5*CW +: CW])
                             + $signed(d[8*CW +: CW])) / 3);
        end
        return d;
    endfunction

    function automatic logic [IN_TDW-1:0] tri_item(input int ax, az, bx, bz, cx, cz,
                                                   input int ay, by, cy, px, py, pz);
        return {CW'(pz), CW'(py), CW'(px), CW'(cz), CW'(cy), CW'(cx),
                CW'(bz), CW'(by), CW'(bx), CW'(az), CW'(ay), CW'(ax)};
    endfunction

    task automatic send(input logic [IN_TDW-1:0] d);
        int g;
        g = gap_len();
        if (g > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [TOLW-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    localparam int ONE = 1 << FB;

    initial begin
        logic [TOLW-1:0] side_set[4];
        logic [TOLW-1:0] plane_set[4];
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        i_cfg_we = 1'b0;
        i_cfg_index = REG_SIDE_TOL;
        i_cfg_data = '0;
        stalls_on = 1'b1;
        side_set  = '{SIDE_TOL_RST, 40'd0, {TOLW{1'b1}}, 40'd1 << 36};
        plane_set = '{PLANE_TOL_RST, 40'd0, {TOLW{1'b1}}, 40'd1 << 38};
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: inside, each exit edge, both windings, extremes, vertical
        send(tri_item(0, 0, 10*ONE, 0, 0, 10*ONE, ONE, 2*ONE, 3*ONE, ONE, 0, ONE));
        send(tri_item(0, 0, 0, 10*ONE, 10*ONE, 0, ONE, 2*ONE, 3*ONE, ONE, 0, ONE));
        send(tri_item(0, 0, 10*ONE, 0, 0, 10*ONE, 0, 0, 0, ONE, 0, -ONE));
        send(tri_item(0, 0, 10*ONE, 0, 0, 10*ONE, 0, 0, 0, 9*ONE, 7, 9*ONE));
        send(tri_item(0, 0, 10*ONE, 0, 0, 10*ONE, 0, 0, 0, -ONE, 0, ONE));
        send(tri_item(0, 0, 10*ONE, 0, 0, 10*ONE, 0, 0, 0, 0, 0, 0));
        send(tri_item(0, 0, ONE, 0, 2*ONE, 0, 0, ONE, 5, ONE, 123, ONE));  // collinear
        send(tri_item(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, -5, 0));               // point triangle
        send(tri_item(0, 0, 1, 0, 0, 1, 32'h7fffffff, 32'h80000000, 0,
                      32'h7fffffff, 0, 32'h80000000));                    // saturate
        send(tri_item(0, 0, 1, 0, 0, 1, 32'h80000000, 32'h7fffffff, 0,
                      32'h7fffffff, 0, 32'h7fffffff));
        send({NIN{RMAX}});
        send({NIN{RMIN}});
        send({6{RMAX, RMIN}});
        send({6{RMIN, RMAX}});
        send('0);
        send('1);
        drain();

        // random phases over register settings, one with no stalls
        for (int ph = 0; ph < 8; ph++) begin
            write_reg(REG_SIDE_TOL, (ph < 4) ? side_set[ph] : TOLW'({$urandom, $urandom}));
            write_reg(REG_PLANE_TOL, (ph < 4) ? plane_set[ph] : TOLW'({$urandom, $urandom}));
            stalls_on = (ph != 5);
            for (int n = 0; n < 250; n++) send(rnd_item());
            drain();
        end

        if (fail_count == 0) $display("SCOREBOARD CLEAN");
        else $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

// ===== files.f =====
rtl/tplh_pkg.sv
rtl/tplh_geom.sv
rtl/tplh_plane.sv
rtl/tplh_div.sv
rtl/triangle_point_locate_height.sv
tb/sv/tplh_checker.sv
tb/sv/tb_triangle_point_locate_height.sv
